// File: rtl/zone_classify_debounce_defines.svh
// Assertion macros shared by the zone classifier and debouncer.
`ifndef ZONE_CLASSIFY_DEBOUNCE_DEFINES_SVH
`define ZONE_CLASSIFY_DEBOUNCE_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define ZCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("zcd check failed");
// Check a property on every clock edge, reset included.
`define ZCD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("zcd check failed");
`else
`define ZCD_ASSERT(lbl, prop)
`define ZCD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/zcd_pkg.sv
// Shared types and constants of the zone classifier and debouncer.
package zcd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 8;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned BOUND_W         = 12;
  localparam int unsigned TICKS_W         = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned APB_ADDR_W      = 4;
  localparam int unsigned APB_DATA_W      = 32;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd3;

  // Target kinds
  localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PACE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ZONE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BPM   = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_LOW   = 2'd1;
  localparam logic [1:0] REG_HIGH  = 2'd2;
  localparam logic [1:0] REG_TICKS = 2'd3;

  typedef enum logic [2:0] {
    ST_NO_TARGET = 3'd0,
    ST_NO_SAMPLE = 3'd1,
    ST_UNDER     = 3'd2,
    ST_IN_ZONE   = 3'd3,
    ST_OVER      = 3'd4
  } zone_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BOUND_W-1:0] low;
    logic [BOUND_W-1:0] high;
    logic [TICKS_W-1:0] ticks;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/zcd_classify.sv
// Front end: accepts samples and classifies them against the target window.
module zcd_classify
  import zcd_pkg::*;
(
  input  cfg_t         cfg_i,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,  // pace_sec_per_km[11:0], heart_zone[14:12], heart_bpm[22:15]
  input  logic [1:0]   s_tuser,  // pace_valid[0], heart_valid[1]
  input  q_stat_t      q_stat_i,
  output logic         push_o,
  output zone_e        class_o
);

  logic               pace_valid;
  logic               heart_valid;
  logic [BOUND_W-1:0] pace;
  logic [BOUND_W-1:0] zone_ext;
  logic [BOUND_W-1:0] bpm_ext;

  // Compare a value against the window, low test first
  function automatic zone_e window_check(logic [BOUND_W-1:0] v,
                                         logic [BOUND_W-1:0] lo,
                                         logic [BOUND_W-1:0] hi);
    zone_e r;
    if (v < lo) begin
      r = ST_UNDER;
    end else if (v > hi) begin
      r = ST_OVER;
    end else begin
      r = ST_IN_ZONE;
    end
    return r;
  endfunction

  // Unpack the request
  assign pace_valid  = s_tuser[0];
  assign heart_valid = s_tuser[1];
  assign pace        = s_tdata[11:0];
  assign zone_ext    = {9'd0, s_tdata[14:12]};
  assign bpm_ext     = {4'd0, s_tdata[22:15]};

  // Accept while the queue has room
  assign s_tready = !q_stat_i.full;
  assign push_o   = s_tvalid && s_tready;

  // Classify; for pace the slow bound is tested first
  always_comb begin
    unique case (cfg_i.kind)
      KIND_PACE: begin
        if (!pace_valid) begin
          class_o = ST_NO_SAMPLE;
        end else if (pace > cfg_i.high) begin
          class_o = ST_UNDER;
        end else if (pace < cfg_i.low) begin
          class_o = ST_OVER;
        end else begin
          class_o = ST_IN_ZONE;
        end
      end
      KIND_ZONE: begin
        class_o = heart_valid ? window_check(zone_ext, cfg_i.low, cfg_i.high) : ST_NO_SAMPLE;
      end
      KIND_BPM: begin
        class_o = heart_valid ? window_check(bpm_ext, cfg_i.low, cfg_i.high) : ST_NO_SAMPLE;
      end
      default: begin
        class_o = ST_NO_TARGET;
      end
    endcase
  end

endmodule

// File: rtl/zcd_queue.sv
// Short queue of classified samples between the front and back ends.
module zcd_queue
  import zcd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  zone_e   push_data_i,
  input  logic    pop_i,
  output zone_e   pop_data_o,
  output q_stat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  zone_e             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries; no reset on payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/zcd_debounce.sv
// Back end: debounces the class stream and registers the emitted cue.
module zcd_debounce
  import zcd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  q_stat_t     q_stat_i,
  input  zone_e       class_i,
  output logic        pop_o,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // cue_state[2:0], zero padded
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;
  localparam logic [COUNT_WIDTH-1:0] RUN_MAX = '1;

  zone_e                  committed_q, committed_d;
  zone_e                  candidate_q, candidate_d;
  logic [COUNT_WIDTH-1:0] run_q, run_d;
  logic                   out_valid_q, out_valid_d;
  zone_e                  cue_q, cue_d;
  logic [COUNT_WIDTH-1:0] run_step;
  logic                   emit;

  // Pop when the output register is free or being drained
  assign pop_o = !q_stat_i.empty && (!out_valid_q || m_tready);

  always_comb begin
    committed_d = committed_q;
    candidate_d = candidate_q;
    run_d       = run_q;
    run_step    = run_q;
    emit        = 1'b0;
    if (pop_o) begin
      if (class_i == committed_q) begin
        candidate_d = class_i;
        run_d       = '0;
      end else begin
        if (class_i == candidate_q) begin
          run_step = (run_q == RUN_MAX) ? run_q : run_q + COUNT_WIDTH'(1);
        end else begin
          candidate_d = class_i;
          run_step    = COUNT_WIDTH'(1);
        end
        run_d = run_step;
        // Commit once the run reaches the configured length
        if (CMP_W'(run_step) >= CMP_W'(cfg_i.ticks)) begin
          committed_d = candidate_d;
          run_d       = '0;
          emit        = 1'b1;
        end
      end
    end
  end

  // Hold or load the output register
  always_comb begin
    out_valid_d = out_valid_q && !m_tready;
    cue_d       = cue_q;
    if (emit) begin
      out_valid_d = 1'b1;
      cue_d       = committed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= ST_NO_TARGET;
      candidate_q <= ST_NO_TARGET;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      committed_q <= committed_d;
      candidate_q <= candidate_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cue_q <= cue_d;
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {5'd0, cue_q};

endmodule

// File: rtl/zone_classify_debounce.sv
// Top level of the zone classifier with debounced cue output.
//
// Input stream s_*: one sensor sample per request; tdata carries pace,
// heart-rate zone and bpm, tuser the two presence flags. Output stream m_*:
// one cue request each time a new class has been seen debounce_ticks samples
// in a row; tdata[2:0] is the newly committed class.
// The APB port writes and reads the four target registers at 0x0, 0x4,
// 0x8 and 0xC; write them only while no samples are in flight.
// Throughput: one sample per cycle while the queue has room. A sample is
// classified as it is accepted and sits in a two-entry queue; the debouncer
// pops one per cycle unless a cue waits on m_tready, and registers each cue.
// When m_tready is low the cue is held in the output register; the queue
// keeps filling, and s_tready drops only once both queue entries are taken.
// Reset clears the queue, the debouncer (committed and candidate class
// no_target, run count zero) and the registers (debounce_ticks to 3).
`include "zone_classify_debounce_defines.svh"

module zone_classify_debounce
  import zcd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,  // pace_sec_per_km[11:0], heart_zone[14:12],
                                          // heart_bpm[22:15]
  input  logic [1:0]            s_tuser,  // pace_valid[0], heart_valid[1]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,  // cue_state[2:0]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg_q, cfg_d;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       push;
  logic       pop;
  zone_e      push_class;
  zone_e      pop_class;
  q_stat_t    q_stat;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_KIND:  cfg_d.kind  = pwdata[KIND_W-1:0];
        REG_LOW:   cfg_d.low   = pwdata[BOUND_W-1:0];
        REG_HIGH:  cfg_d.high  = pwdata[BOUND_W-1:0];
        REG_TICKS: cfg_d.ticks = pwdata[TICKS_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KIND:  prdata = {{(APB_DATA_W-KIND_W){1'b0}}, cfg_q.kind};
      REG_LOW:   prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, cfg_q.low};
      REG_HIGH:  prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, cfg_q.high};
      REG_TICKS: prdata = {{(APB_DATA_W-TICKS_W){1'b0}}, cfg_q.ticks};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind  <= KIND_OPEN;
      cfg_q.low   <= '0;
      cfg_q.high  <= '0;
      cfg_q.ticks <= TICKS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  zcd_classify u_classify (
    .cfg_i    (cfg_q),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat_i (q_stat),
    .push_o   (push),
    .class_o  (push_class)
  );

  zcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_class),
    .pop_i       (pop),
    .pop_data_o  (pop_class),
    .stat_o      (q_stat)
  );

  zcd_debounce #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_stat_i (q_stat),
    .class_i  (pop_class),
    .pop_o    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A full queue never accepts
  `ZCD_ASSERT_ALWAYS(a_no_push_when_full, !(q_stat.full && s_tready))
  // Nothing is popped from an empty queue
  `ZCD_ASSERT_ALWAYS(a_no_pop_when_empty, !(q_stat.empty && pop))
  // A new cue comes only from a queued sample
  `ZCD_ASSERT(a_cue_from_queue, $rose(m_tvalid) |-> $past(!q_stat.empty))
  // A kind write lands in the register
  `ZCD_ASSERT(a_kind_write, (cfg_wr && reg_idx == REG_KIND) |=> cfg_q.kind == $past(pwdata[1:0]))

endmodule

// File: verif/tb_zone_classify_debounce.sv
`timescale 1ns / 1ps
// Self-checking bench for the zone classifier: APB setup, sample stream in, cue stream out.
module tb;
  import zcd_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MAX_REPORTS     = 10;

  // Where a shaped sample lands relative to the current window
  localparam int unsigned REGION_BELOW   = 0;
  localparam int unsigned REGION_INSIDE  = 1;
  localparam int unsigned REGION_ABOVE   = 2;
  localparam int unsigned REGION_MISSING = 3;
  localparam int unsigned REGION_NOISE   = 4;

  typedef struct packed {
    logic               pace_ok;
    logic [BOUND_W-1:0] pace;
    logic               heart_ok;
    logic [2:0]         zone;
    logic [7:0]         bpm;
  } sample_t;

  // Predicts the debounced cue stream and holds the cues still owed by the block.
  class cue_predictor;
    logic [KIND_W-1:0]          kind;
    logic [BOUND_W-1:0]         low;
    logic [BOUND_W-1:0]         high;
    logic [TICKS_W-1:0]         ticks;
    zone_e                      committed;
    zone_e                      candidate;
    logic [COUNT_WIDTH_DEF-1:0] run;
    zone_e                      pending_cues[$];
    int unsigned                errors;

    function new();
      kind      = KIND_OPEN;
      low       = '0;
      high      = '0;
      ticks     = TICKS_RESET;
      committed = ST_NO_TARGET;
      candidate = ST_NO_TARGET;
      run       = '0;
      errors    = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_KIND:  kind  = value[KIND_W-1:0];
        REG_LOW:   low   = value[BOUND_W-1:0];
        REG_HIGH:  high  = value[BOUND_W-1:0];
        REG_TICKS: ticks = value[TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    // Map one sample onto the target window
    function zone_e classify(sample_t s);
      logic [BOUND_W-1:0] v;
      case (kind)
        KIND_PACE: begin
          // larger pace is slower, so the slow bound gives under
          if (!s.pace_ok) return ST_NO_SAMPLE;
          if (s.pace > high) return ST_UNDER;
          if (s.pace < low) return ST_OVER;
          return ST_IN_ZONE;
        end
        KIND_ZONE, KIND_BPM: begin
          if (!s.heart_ok) return ST_NO_SAMPLE;
          v = (kind == KIND_ZONE) ? {9'd0, s.zone} : {4'd0, s.bpm};
          if (v < low) return ST_UNDER;
          if (v > high) return ST_OVER;
          return ST_IN_ZONE;
        end
        default: return ST_NO_TARGET;
      endcase
    endfunction

    // Advance the debouncer by one accepted sample
    function void note_sample(sample_t s);
      zone_e seen;
      seen = classify(s);
      if (seen == committed) begin
        candidate = seen;
        run = '0;
        return;
      end
      if (seen == candidate) begin
        if (run != '1) run++;
      end else begin
        candidate = seen;
        run = {{(COUNT_WIDTH_DEF-1){1'b0}}, 1'b1};
      end
      if (run >= ticks) begin
        committed = candidate;
        run = '0;
        pending_cues.push_back(committed);
      end
    endfunction

    function void check_cue(logic [7:0] got);
      zone_e want;
      if (pending_cues.size() == 0) begin
        flag($sformatf("cue_state expected none, actual %0d", got));
        return;
      end
      want = pending_cues.pop_front();
      if (got !== {5'd0, want})
        flag($sformatf("cue_state expected %0d, actual %0d", want, got));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [23:0]           s_tdata;   // pace[11:0], zone[14:12], bpm[22:15], pad[23]
  logic [1:0]            s_tuser;   // pace_valid[0], heart_valid[1]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;   // cue_state[2:0], pad[7:3]
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cue_predictor book;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_cycles;

  zone_classify_debounce dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sample_t sample_of(logic pv, int unsigned pace, logic hv,
                                        int unsigned zone, int unsigned bpm);
    sample_t s;
    s.pace_ok  = pv;
    s.pace     = pace[BOUND_W-1:0];
    s.heart_ok = hv;
    s.zone     = zone[2:0];
    s.bpm      = bpm[7:0];
    return s;
  endfunction

  // Build a sample that falls in the given region of the current window
  function automatic sample_t shaped_sample(int unsigned region);
    sample_t     s;
    logic [31:0] r;
    int unsigned top, v;
    r = $urandom;
    s.pace_ok  = r[0];
    s.pace     = r[12:1];
    s.heart_ok = r[13];
    s.zone     = r[16:14];
    s.bpm      = r[24:17];
    top = (book.kind == KIND_PACE) ? 4095 : (book.kind == KIND_ZONE) ? 7 : 255;
    if (book.kind == KIND_OPEN || region == REGION_NOISE) return s;
    case (region)
      REGION_BELOW:
        if (book.low == 0) v = $urandom_range(top);
        else v = $urandom_range(0, (book.low - 1 > top) ? top : book.low - 1);
      REGION_ABOVE:
        if (book.high >= top) v = $urandom_range(top);
        else v = $urandom_range(book.high + 1, top);
      default:
        v = $urandom_range((book.low > top) ? top : book.low,
                           (book.high > top) ? top : book.high);
    endcase
    case (book.kind)
      KIND_PACE: begin
        s.pace_ok = (region != REGION_MISSING);
        s.pace    = v[BOUND_W-1:0];
      end
      KIND_ZONE: begin
        s.heart_ok = (region != REGION_MISSING);
        s.zone     = v[2:0];
      end
      default: begin
        s.heart_ok = (region != REGION_MISSING);
        s.bpm      = v[7:0];
      end
    endcase
    return s;
  endfunction

  // Offer one sample request, with random idle cycles ahead of it
  task automatic send_sample(input sample_t s);
    logic [31:0] junk;
    while ($urandom_range(99) < send_idle_pct) begin
      junk = $urandom;
      s_tvalid <= 1'b0;
      s_tdata  <= junk[23:0];
      s_tuser  <= junk[25:24];
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, s.bpm, s.zone, s.pace};
    s_tuser  <= {s.heart_ok, s.pace_ok};
    do @(posedge clk_i); while (!s_tready);
    book.note_sample(s);
  endtask

  // Drop valid and let every owed cue and any silent sample drain out
  task automatic wait_for_quiet();
    s_tvalid <= 1'b0;
    while (book.pending_cues.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer; psel stays high so back-to-back transfers never glitch it
  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] value,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
  endtask

  // Write a register, then read it back
  task automatic config_write(input logic [1:0] idx, input int unsigned value);
    logic [31:0] rd;
    logic [31:0] mask;
    mask = (idx == REG_KIND) ? 32'h3 : (idx == REG_TICKS) ? 32'hFF : 32'hFFF;
    apb_access(1'b1, idx, value, rd);
    book.write_reg(idx, value);
    apb_access(1'b0, idx, 32'd0, rd);
    if (rd !== (value & mask))
      book.flag($sformatf("register %0d expected %0h, actual %0h", idx, value & mask, rd));
  endtask

  task automatic set_config(input logic [KIND_W-1:0] kind, input int unsigned low,
                            input int unsigned high, input int unsigned ticks);
    wait_for_quiet();
    config_write(REG_KIND, kind);
    config_write(REG_LOW, low);
    config_write(REG_HIGH, high);
    config_write(REG_TICKS, ticks);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random window for a kind; now and then inverted
  task automatic random_config(input logic [KIND_W-1:0] kind, input int unsigned ticks);
    int unsigned top, lo, hi;
    top = (kind == KIND_ZONE) ? 7 : (kind == KIND_BPM) ? 255 : 4095;
    lo  = $urandom_range(top);
    hi  = $urandom_range(top, lo);
    if ($urandom_range(7) == 0) set_config(kind, hi, lo, ticks);
    else set_config(kind, lo, hi, ticks);
  endtask

  // Runs of samples from one region, mostly long enough to commit
  task automatic random_phase(input int unsigned n_items);
    int unsigned sent, run_len, region, span;
    sent = 0;
    while (sent < n_items) begin
      region = $urandom_range(REGION_NOISE);
      span = (book.ticks == 0) ? 1 : book.ticks;
      if ($urandom_range(3) == 0) run_len = $urandom_range(1, span);
      else run_len = span + $urandom_range(2);
      repeat (run_len) begin
        send_sample(shaped_sample(region));
        sent++;
      end
    end
  endtask

  // Cue receiver: random stalls, plus a long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk_i);
      if (m_tvalid && m_tready) book.check_cue(m_tdata);
    end
  end

  // Watchdog: end the run when no request moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    book           = new();
    send_idle_pct  = 8;
    recv_stall_pct = 62;
    hold_cycles    = 0;
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset state: open target matches the committed class, so no cue
    send_sample(sample_of(1'b1, 0, 1'b1, 0, 0));
    send_sample(sample_of(1'b0, 4095, 1'b0, 7, 255));

    // Pace window, single-sample commit, field extremes and both bounds
    set_config(KIND_PACE, 300, 360, 1);
    send_sample(sample_of(1'b0, 330, 1'b1, 3, 100));
    send_sample(sample_of(1'b1, 4095, 1'b0, 0, 0));
    send_sample(sample_of(1'b1, 0, 1'b0, 0, 0));
    send_sample(sample_of(1'b1, 300, 1'b0, 0, 0));
    send_sample(sample_of(1'b1, 360, 1'b0, 0, 0));
    send_sample(sample_of(1'b1, 361, 1'b0, 0, 0));
    send_sample(sample_of(1'b1, 299, 1'b0, 0, 0));
    send_sample(sample_of(1'b1, 330, 1'b0, 0, 0));

    // Zone window with zero debounce: commit at once
    set_config(KIND_ZONE, 2, 4, 0);
    send_sample(sample_of(1'b1, 0, 1'b0, 3, 0));
    send_sample(sample_of(1'b0, 0, 1'b1, 0, 0));
    send_sample(sample_of(1'b0, 0, 1'b1, 7, 0));
    send_sample(sample_of(1'b0, 0, 1'b1, 3, 0));

    // Bpm window, two in a row, then a broken run
    set_config(KIND_BPM, 60, 180, 2);
    send_sample(sample_of(1'b0, 0, 1'b1, 0, 255));
    send_sample(sample_of(1'b0, 0, 1'b1, 0, 255));
    send_sample(sample_of(1'b0, 0, 1'b1, 0, 0));
    send_sample(sample_of(1'b0, 0, 1'b1, 0, 0));
    send_sample(sample_of(1'b0, 0, 1'b1, 0, 120));
    send_sample(sample_of(1'b0, 0, 1'b1, 0, 255));

    // Inverted windows: the check order decides
    set_config(KIND_PACE, 500, 100, 1);
    send_sample(sample_of(1'b1, 300, 1'b0, 0, 0));
    send_sample(sample_of(1'b1, 50, 1'b0, 0, 0));
    send_sample(sample_of(1'b1, 4095, 1'b0, 0, 0));
    set_config(KIND_BPM, 200, 100, 1);
    send_sample(sample_of(1'b0, 0, 1'b1, 0, 150));
    send_sample(sample_of(1'b0, 0, 1'b1, 0, 250));

    // Slow receiver, with a long hold-off while samples keep coming
    random_config(KIND_PACE, 1);
    hold_cycles = HOLD_OFF_CYCLES;
    random_phase(100);
    random_config(KIND_ZONE, 3);
    random_phase(100);
    set_config(KIND_BPM, 0, 4095, 2);
    random_phase(50);

    // Slow sender
    send_idle_pct  = 62;
    recv_stall_pct = 8;
    random_config(KIND_BPM, 4);
    random_phase(120);
    set_config(KIND_OPEN, 4095, 4095, 1);
    random_phase(30);
    set_config(KIND_PACE, 4095, 0, 2);
    random_phase(60);

    // No idling: longest debounce, then another hold-off
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(KIND_BPM, 100, 200, 255);
    repeat (255) send_sample(shaped_sample(REGION_BELOW));
    repeat (255) send_sample(shaped_sample(REGION_ABOVE));
    random_config(KIND_ZONE, 1);
    hold_cycles = HOLD_OFF_CYCLES;
    random_phase(80);

    wait_for_quiet();
    if (book.errors == 0 && book.pending_cues.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: zone_classify_debounce.f
+incdir+rtl
rtl/zcd_pkg.sv
rtl/zcd_classify.sv
rtl/zcd_queue.sv
rtl/zcd_debounce.sv
rtl/zone_classify_debounce.sv
verif/tb_zone_classify_debounce.sv
